@@ sv/dus_pkg.sv @@
`timescale 1ns / 1ps
// Types and constants shared by the text block dot unstuffer.
// No dependencies; every other file imports this package.
package dus_pkg;

   localparam int ByteWidth         = 8;
   localparam int MaxResults        = 3;
   localparam int ResultCountWidth  = 2;
   localparam int QueueDepthDefault = 2;

   localparam logic [ByteWidth-1:0] DotChar = 8'h2E;
   localparam logic [ByteWidth-1:0] CrChar  = 8'h0D;
   localparam logic [ByteWidth-1:0] LfChar  = 8'h0A;
   localparam logic [ByteWidth-1:0] NulChar = 8'h00;

   // Where the parser stands within the current line
   typedef enum logic [1:0] {
      PH_START,
      PH_DOT,
      PH_LINE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      cr_pending;
      logic      line_truncated;
      logic      end_armed;
   } parse_state_type;

   // All results caused by one input byte, as queued between front and back
   typedef struct packed {
      logic [MaxResults-1:0][ByteWidth-1:0] bytes;
      logic [ResultCountWidth-1:0]          count;
      logic                                 text_end;
   } entry_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   localparam parse_state_type ParseReset = '{
      phase:          PH_START,
      cr_pending:     1'b0,
      line_truncated: 1'b0,
      end_armed:      1'b0
   };

endpackage

@@ sv/dus_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request bytes and the result bytes.
// Depends on dus_pkg for the byte width.
interface dus_req_if import dus_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 new_response;

   modport source (output valid, data_byte, new_response, input ready);
   modport sink   (input valid, data_byte, new_response, output ready);
endinterface

interface dus_rsp_if import dus_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 text_end;
   logic                 last;

   modport source (output valid, out_byte, text_end, last, input ready);
   modport sink   (input valid, out_byte, text_end, last, output ready);
endinterface

@@ sv/dus_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts raw bytes, runs the line parser and forms one queue entry
// holding every result the byte causes. Depends on dus_pkg.
module dus_front import dus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [ByteWidth-1:0] data_byte,
   input  logic                 new_response,
   input  logic                 queue_full,
   output logic                 push,
   output entry_type            push_entry
);

   typedef struct packed {
      parse_state_type st;
      entry_type       e;
   } step_type;

   parse_state_type state_ff;
   parse_state_type state_in;
   step_type        step;
   logic            accept;

   // Append one result byte, capped at the entry size
   function automatic step_type emit_byte(input step_type s, input logic [ByteWidth-1:0] b);
      step_type r;
      r = s;
      if (r.e.count != ResultCountWidth'(MaxResults)) begin
         r.e.bytes[r.e.count] = b;
         r.e.count            = r.e.count + ResultCountWidth'(1);
      end
      return r;
   endfunction

   // Handle one byte of line content
   function automatic step_type take_data(input step_type s, input logic [ByteWidth-1:0] d);
      step_type r;
      r = s;
      case (r.st.phase)
         PH_START: begin
            if (d == DotChar) begin
               r.st.phase = PH_DOT;
            end else if (d == NulChar) begin
               r.st.line_truncated = 1'b1;
               r.st.phase          = PH_LINE;
            end else begin
               r          = emit_byte(r, d);
               r.st.phase = PH_LINE;
            end
         end
         PH_DOT: begin
            if (d == DotChar) begin
               r = emit_byte(r, DotChar);
            end else if (d == NulChar) begin
               r.st.end_armed      = 1'b1;
               r.st.line_truncated = 1'b1;
            end else begin
               r = emit_byte(r, DotChar);
               r = emit_byte(r, d);
            end
            r.st.phase = PH_LINE;
         end
         PH_LINE: begin
            if (r.st.line_truncated || r.st.end_armed) begin
               r = r;
            end else if (d == NulChar) begin
               r.st.line_truncated = 1'b1;
            end else begin
               r = emit_byte(r, d);
            end
         end
         default: begin
            r = r;
         end
      endcase
      return r;
   endfunction

   // Next parser state and the results of this byte
   always_comb begin
      step.st = new_response ? ParseReset : state_ff;
      step.e  = '0;
      if (step.st.phase != PH_DONE) begin
         if (step.st.cr_pending) begin
            if (data_byte == LfChar) begin
               if (step.st.phase == PH_DOT || step.st.end_armed) begin
                  step.e.text_end = 1'b1;
                  step            = emit_byte(step, NulChar);
                  step.st.phase   = PH_DONE;
               end else begin
                  step          = emit_byte(step, LfChar);
                  step.st.phase = PH_START;
               end
               step.st.line_truncated = 1'b0;
               step.st.end_armed      = 1'b0;
               step.st.cr_pending     = 1'b0;
            end else begin
               step.st.cr_pending = 1'b0;
               step               = take_data(step, CrChar);
               if (data_byte == CrChar) begin
                  step.st.cr_pending = 1'b1;
               end else begin
                  step = take_data(step, data_byte);
               end
            end
         end else if (data_byte == CrChar) begin
            step.st.cr_pending = 1'b1;
         end else begin
            step = take_data(step, data_byte);
         end
      end
      state_in = accept ? step.st : state_ff;
   end

   // Handshake and queue push
   always_comb begin
      in_ready   = !queue_full;
      accept     = in_valid && in_ready;
      push       = accept && (step.e.count != '0);
      push_entry = step.e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ParseReset;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/dus_queue.sv @@
`timescale 1ns / 1ps
// Short register queue of result entries between front and back end.
// Depends on dus_pkg for the entry type.
module dus_queue import dus_pkg::*; #(
   parameter int Depth = QueueDepthDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_entry,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   entry_type               slots_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   fill_ff, fill_in;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CountWidth'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CountWidth'(1);
      end
   end

   assign full       = (fill_ff == CountWidth'(Depth));
   assign head.valid = (fill_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Write the incoming entry
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ sv/dus_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the queued entry into the output register, one result per
// cycle unless out_ready stalls. Depends on dus_pkg for the entry and head types.
module dus_back import dus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  queue_head_type       head,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [ByteWidth-1:0] out_byte,
   output logic                 text_end,
   output logic                 last
);

   logic [ResultCountWidth-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic [ByteWidth-1:0]        byte_ff, byte_in;
   logic                        end_ff, end_in;
   logic                        last_ff, last_in;
   logic                        take;
   logic                        final_result;

   // Load the next result whenever the output register is free or drains
   always_comb begin
      take         = head.valid && (!valid_ff || out_ready);
      final_result = (idx_ff == head.entry.count - ResultCountWidth'(1));
      pop          = take && final_result;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      if (take) begin
         idx_in   = final_result ? '0 : idx_ff + ResultCountWidth'(1);
         valid_in = 1'b1;
         byte_in  = head.entry.bytes[idx_ff];
         end_in   = head.entry.text_end;
         last_in  = final_result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the payload with its transfer
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign text_end  = end_ff;
   assign last      = last_ff;

endmodule

@@ sv/text_block_dot_unstuffer.sv @@
`timescale 1ns / 1ps
// Dot unstuffer for CR LF delimited multi-line text responses.
// Depends on dus_pkg, dus_if, dus_front, dus_queue and dus_back.
//
// req_if carries one raw byte per transfer; new_response set on a byte clears
// the parser before that byte. rsp_if carries the unstuffed bytes, each line
// ending in a single LF, and an end marker (text_end set, out_byte zero) after
// the terminating dot line. last flags the final result of each input byte;
// a byte may yield no result at all (CR, held dot, dropped or post-end bytes).
// A request transfer reaches rsp_if through the result queue and then the
// output register. Throughput is one input byte per cycle while each byte
// yields at most one result and the receiver does not stall; a byte with two
// or three results holds the output while the single output register drains
// them one result a cycle. The queue between parser and output lets the
// front keep taking bytes while a result waits; when the receiver stalls the
// queue fills and req_if.ready drops. Reset clears the parser to line start
// and empties queue and output.
module text_block_dot_unstuffer import dus_pkg::*; #(
   parameter int QueueDepth = QueueDepthDefault
) (
   input logic       clock,
   input logic       reset,
   dus_req_if.sink   req_if,
   dus_rsp_if.source rsp_if
);

   logic           queue_full;
   logic           push;
   entry_type      push_entry;
   logic           pop;
   queue_head_type head;

   // Parse and classify
   dus_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_ready     (req_if.ready),
      .data_byte    (req_if.data_byte),
      .new_response (req_if.new_response),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Decouple parser from output
   dus_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   // Serialize results
   dus_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_byte  (rsp_if.out_byte),
      .text_end  (rsp_if.text_end),
      .last      (rsp_if.last)
   );

endmodule

@@ sim/tb_text_block_dot_unstuffer.sv @@
`timescale 1ns / 1ps
// Self-checking bench for text_block_dot_unstuffer: directed rows, then random responses.
// Depends on dus_pkg, dus_if and the unstuffer RTL; checks every result against its row or a predictor.
module tb_text_block_dot_unstuffer;
   import dus_pkg::*;

   localparam int  RandomItems   = 110;
   localparam int  HoldCycles    = 80;
   localparam int  DrainCycles   = 8;
   localparam int  WatchdogLimit = 1000;
   localparam int  NumDirected   = 28;
   localparam logic Fixed        = 1'b1;
   localparam logic Predicted    = 1'b0;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 text_end;
      logic                 last;
   } text_result_type;

   // One stimulus byte; fixed rows carry their result typed in (none or one)
   typedef struct packed {
      logic [ByteWidth-1:0]        data_byte;
      logic                        new_response;
      logic                        fixed;
      logic [ResultCountWidth-1:0] count;
      logic [ByteWidth-1:0]        first_byte;
      logic                        text_end;
   } stim_row_type;

   localparam stim_row_type DirectedRows [NumDirected] = '{
      '{8'h41,   1'b0, Fixed,     2'd1, 8'h41,   1'b0},  // plain byte at line start
      '{8'hFF,   1'b0, Fixed,     2'd1, 8'hFF,   1'b0},  // top byte value
      '{NulChar, 1'b0, Fixed,     2'd0, NulChar, 1'b0},  // NUL drops rest of line
      '{8'h5A,   1'b0, Fixed,     2'd0, NulChar, 1'b0},
      '{CrChar,  1'b0, Fixed,     2'd0, NulChar, 1'b0},
      '{LfChar,  1'b0, Fixed,     2'd1, LfChar,  1'b0},
      '{DotChar, 1'b0, Fixed,     2'd0, NulChar, 1'b0},  // held dot
      '{CrChar,  1'b0, Fixed,     2'd0, NulChar, 1'b0},
      '{8'h71,   1'b0, Predicted, 2'd0, NulChar, 1'b0},  // dot, lone CR and byte
      '{LfChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},  // lone LF
      '{CrChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{CrChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},  // CR after CR
      '{LfChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{DotChar, 1'b0, Predicted, 2'd0, NulChar, 1'b0},  // stuffed dot
      '{DotChar, 1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{CrChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{LfChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{CrChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},  // empty line
      '{LfChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{DotChar, 1'b0, Fixed,     2'd0, NulChar, 1'b0},  // terminating dot line
      '{CrChar,  1'b0, Fixed,     2'd0, NulChar, 1'b0},
      '{LfChar,  1'b0, Fixed,     2'd1, NulChar, 1'b1},
      '{8'h6B,   1'b0, Fixed,     2'd0, NulChar, 1'b0},  // ignored after the end
      '{CrChar,  1'b1, Predicted, 2'd0, NulChar, 1'b0},
      '{DotChar, 1'b1, Predicted, 2'd0, NulChar, 1'b0},  // pending CR discarded
      '{NulChar, 1'b0, Predicted, 2'd0, NulChar, 1'b0},  // dot then NUL ends text
      '{CrChar,  1'b0, Predicted, 2'd0, NulChar, 1'b0},
      '{LfChar,  1'b0, Fixed,     2'd1, NulChar, 1'b1}
   };

   logic clock = 1'b0;
   logic reset;

   dus_req_if req_if ();
   dus_rsp_if rsp_if ();

   text_block_dot_unstuffer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   text_result_type expected_text_q [$];
   stim_row_type    stim_q [$];
   text_result_type step_out [MaxResults];
   int              step_count;
   int              mismatches  = 0;
   int              live_items  = 0;
   int              idle_cycles = 0;
   logic            steady      = 1'b0;
   logic            hold_output = 1'b0;

   // Predictor state
   phase_type cur_phase;
   logic      cr_held;
   logic      dropping;
   logic      dot_nul_end;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor: collect the results of one byte into step_out
   function automatic void put_result(logic [ByteWidth-1:0] b, logic endmark);
      if (step_count < MaxResults) begin
         step_out[step_count] = '{b, endmark, 1'b0};
         step_count++;
      end
   endfunction

   function automatic void take_content(logic [ByteWidth-1:0] d);
      case (cur_phase)
         PH_START: begin
            if (d == DotChar) begin
               cur_phase = PH_DOT;
            end else if (d == NulChar) begin
               dropping  = 1'b1;
               cur_phase = PH_LINE;
            end else begin
               put_result(d, 1'b0);
               cur_phase = PH_LINE;
            end
         end
         PH_DOT: begin
            if (d == DotChar) begin
               put_result(DotChar, 1'b0);
            end else if (d == NulChar) begin
               dot_nul_end = 1'b1;
               dropping    = 1'b1;
            end else begin
               put_result(DotChar, 1'b0);
               put_result(d, 1'b0);
            end
            cur_phase = PH_LINE;
         end
         PH_LINE: begin
            if (!(dropping || dot_nul_end)) begin
               if (d == NulChar) dropping = 1'b1;
               else put_result(d, 1'b0);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void take_line_end();
      if (cur_phase == PH_DOT || dot_nul_end) begin
         put_result(NulChar, 1'b1);
         cur_phase = PH_DONE;
      end else begin
         put_result(LfChar, 1'b0);
         cur_phase = PH_START;
      end
      dropping    = 1'b0;
      dot_nul_end = 1'b0;
      cr_held     = 1'b0;
   endfunction

   // Returns 1 when the byte is ignored because the text has ended
   function automatic logic unstuff_byte(logic [ByteWidth-1:0] d, logic nr);
      step_count = 0;
      if (nr) begin
         cur_phase   = PH_START;
         cr_held     = 1'b0;
         dropping    = 1'b0;
         dot_nul_end = 1'b0;
      end
      if (cur_phase == PH_DONE) return 1'b1;
      if (cr_held) begin
         if (d == LfChar) begin
            take_line_end();
         end else begin
            cr_held = 1'b0;
            take_content(CrChar);
            if (d == CrChar) cr_held = 1'b1;
            else take_content(d);
         end
      end else if (d == CrChar) begin
         cr_held = 1'b1;
      end else begin
         take_content(d);
      end
      if (step_count > 0) step_out[step_count-1].last = 1'b1;
      return 1'b0;
   endfunction

   // Offer one byte, wait for its transfer, then record what it should produce
   task automatic send_byte(stim_row_type row);
      int   gap;
      logic ignored;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= row.data_byte;
      req_if.new_response <= row.new_response;
      do @(posedge clock); while (!req_if.ready);
      ignored = unstuff_byte(row.data_byte, row.new_response);
      if (!ignored) live_items++;
      if (row.fixed) begin
         if (row.count != 0) expected_text_q.push_back('{row.first_byte, row.text_end, 1'b1});
      end else begin
         for (int k = 0; k < step_count; k++) expected_text_q.push_back(step_out[k]);
      end
   endtask

   // Drop valid and hold until every expected result has come out
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_text_q.size() != 0);
   endtask

   function automatic logic [ByteWidth-1:0] random_text_byte();
      if ($urandom_range(0, 7) == 0) return ByteWidth'($urandom_range(0, 255));
      return ByteWidth'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic void add_byte(logic [ByteWidth-1:0] b);
      stim_q.push_back('{b, 1'b0, Predicted, '0, NulChar, 1'b0});
   endfunction

   function automatic void add_text(int n);
      repeat (n) add_byte(random_text_byte());
   endfunction

   // Build one response: mostly well-formed lines and an end line, sometimes noise
   function automatic void make_response();
      stim_q.delete();
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(4, 12))
            stim_q.push_back('{ByteWidth'($urandom_range(0, 255)),
                               1'($urandom_range(0, 7) == 0), Predicted, '0, NulChar, 1'b0});
      end else begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: add_text($urandom_range(0, 6));
               4, 5: begin
                  add_byte(DotChar);
                  add_byte(DotChar);
                  add_text($urandom_range(0, 4));
               end
               6: begin
                  add_byte(DotChar);
                  add_byte(ByteWidth'($urandom_range(8'h30, 8'h7E)));
                  add_text($urandom_range(0, 3));
               end
               7: begin
                  add_text(1);
                  add_byte(CrChar);
                  add_text(1);
                  add_byte(LfChar);
                  add_text(1);
               end
               8: ;
               default: begin
                  add_text($urandom_range(0, 3));
                  add_byte(NulChar);
                  add_text($urandom_range(0, 3));
               end
            endcase
            add_byte(CrChar);
            add_byte(LfChar);
         end
         case ($urandom_range(0, 3))
            0, 1: begin
               add_byte(DotChar);
               add_byte(CrChar);
               add_byte(LfChar);
            end
            2: begin
               add_byte(DotChar);
               add_byte(NulChar);
               add_text($urandom_range(0, 2));
               add_byte(CrChar);
               add_byte(LfChar);
            end
            default: ;
         endcase
         if ($urandom_range(0, 1) == 1) add_text($urandom_range(0, 3));
      end
      stim_q[0].new_response = 1'b1;
   endfunction

   // Stimulus and end of run
   initial begin
      int  random_base;
      logic hold_done;
      logic pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      cur_phase   = PH_START;
      cr_held     = 1'b0;
      dropping    = 1'b0;
      dot_nul_end = 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= '0;
      req_if.new_response <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i]) send_byte(DirectedRows[i]);
      wait_for_drain();

      random_base = live_items;
      while (live_items - random_base < RandomItems) begin
         make_response();
         steady = ($urandom_range(0, 4) == 0);
         if (!hold_done && live_items - random_base >= 50) begin
            hold_output = 1'b1;
            hold_done   = 1'b1;
         end
         if (!pause_done && live_items - random_base >= 100) begin
            wait_for_drain();
            pause_done = 1'b1;
         end
         foreach (stim_q[k]) send_byte(stim_q[k]);
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("text_block_dot_unstuffer regression: pass");
      else
         $display("text_block_dot_unstuffer regression: fail");
      $finish;
   end

   // Receiver: random stalls, plus one long hold to back up the block
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_output = 1'b0;
         end
         gap = steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Compare each result transfer with the oldest expected result
   always @(posedge clock) begin
      text_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_text_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual out_byte %h text_end %b last %b",
                     $time, rsp_if.out_byte, rsp_if.text_end, rsp_if.last);
            mismatches++;
         end else begin
            want = expected_text_q.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                        rsp_if.out_byte);
               mismatches++;
            end
            if (rsp_if.text_end !== want.text_end) begin
               $display("%0t: text_end expected %b actual %b", $time, want.text_end,
                        rsp_if.text_end);
               mismatches++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_if.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                     idle_cycles, expected_text_q.size());
            $display("text_block_dot_unstuffer regression: fail");
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
sv/dus_pkg.sv
sv/dus_if.sv
sv/dus_front.sv
sv/dus_queue.sv
sv/dus_back.sv
sv/text_block_dot_unstuffer.sv
sim/tb_text_block_dot_unstuffer.sv
